/* sv/vision_frame_receiver_core_macros.svh */
// assertion macros used by the frame receiver checker
`ifndef VISION_FRAME_RECEIVER_CORE_MACROS_SVH
`define VISION_FRAME_RECEIVER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define VFR_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("vfr check failed");

// next-cycle implication, sampled on clk, off during reset
`define VFR_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vfr check failed");

`endif

/* sv/vfr_pkg.sv */
// package: item types, frame constants and result codes of the frame receiver
package vfr_pkg;

    // default frame length in bytes
    localparam int FRAME_LEN_DEF = 12;

    // frame marker and field codes
    localparam logic [7:0] HDR_BYTE      = 8'hED;
    localparam logic [7:0] TRL_BYTE      = 8'hEC;
    localparam logic [7:0] CLASS_A_BYTE  = 8'h77;
    localparam logic [7:0] CLASS_B_BYTE  = 8'h88;
    localparam logic [7:0] MODE_WM_BYTE  = 8'h55;
    localparam logic [7:0] MODE_ARM_BYTE = 8'h00;

    // input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    // target class codes
    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_A    = 2'd1;
    localparam logic [1:0] CLS_B    = 2'd2;

    // buzzer command codes
    localparam logic [1:0] BUZ_OFF  = 2'd0;
    localparam logic [1:0] BUZ_SOFT = 2'd1;
    localparam logic [1:0] BUZ_LOUD = 2'd2;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        frame_ok;
        logic [31:0] yaw_bits;
        logic [31:0] pitch_bits;
        logic [31:0] prev_pitch_bits;
        logic [1:0]  target_class;
        logic        mode_windmill;
        logic [1:0]  buzzer_cmd;
        logic [15:0] frame_count;
    } out_item_t;

    // decoded view of the frame store
    typedef struct packed {
        logic        ok;
        logic [31:0] yaw;
        logic [31:0] pitch;
        logic [1:0]  cls;
        logic        mode_set;
        logic        mode_clr;
    } frame_dec_t;

    // store update request from the pipeline stage
    typedef struct packed {
        logic       wr;
        logic [7:0] data;
        logic       clr;
    } store_cmd_t;

endpackage

/* sv/vfr_if.sv */
// valid/ready channel interfaces for input and result items
interface vfr_in_if
    import vfr_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface vfr_out_if
    import vfr_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* sv/vfr_frame_store.sv */
// frame store: byte fill with drop when full, and parallel decode of the held frame
module vfr_frame_store
    import vfr_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_cmd_t cmd,
    output frame_dec_t dec
);

    localparam int CNT_W = $clog2(FRAME_LEN + 1);
    localparam int IDX_W = $clog2(FRAME_LEN);

    logic [7:0]       store_reg  [FRAME_LEN];
    logic [7:0]       store_next [FRAME_LEN];
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             has_room;

    assign has_room = (fill_reg < CNT_W'(FRAME_LEN));

    // write position and fill count, cleared at each idle
    always_comb
    begin
        store_next = store_reg;
        fill_next  = fill_reg;
        if (cmd.clr)
        begin
            fill_next = '0;
        end
        else if (cmd.wr && has_room)
        begin
            store_next[fill_reg[IDX_W-1:0]] = cmd.data;
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            fill_reg  <= fill_next;
            store_reg <= store_next;
        end
    end

    // header/trailer check and field extraction
    always_comb
    begin
        dec.ok    = (store_reg[0] == HDR_BYTE) && (store_reg[FRAME_LEN-1] == TRL_BYTE);
        dec.yaw   = {store_reg[4], store_reg[3], store_reg[2], store_reg[1]};
        dec.pitch = {store_reg[8], store_reg[7], store_reg[6], store_reg[5]};
        case (store_reg[9])
            CLASS_A_BYTE: dec.cls = CLS_A;
            CLASS_B_BYTE: dec.cls = CLS_B;
            default:      dec.cls = CLS_NONE;
        endcase
        dec.mode_set = (store_reg[10] == MODE_WM_BYTE);
        dec.mode_clr = (store_reg[10] == MODE_ARM_BYTE);
    end

endmodule

/* sv/vision_frame_receiver_core.sv */
// Frame receiver top level. Items are either a received byte or a line-idle event; one item
// is taken per clock unless input is held back. An item is registered in the entry register
// and handled from there; an idle event's result is written into the result register, from
// which it is offered on the output. Bytes give no result. Input is held back only while a
// finished result waits in the result register and the item in the entry register is an idle
// event; there is a single entry register and a single result register.
module vision_frame_receiver_core
    import vfr_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    vfr_in_if.sink    in_chan,
    vfr_out_if.source out_chan
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    in_item_t    s1_item_reg;
    logic        s1_adv;
    logic        s1_idle;
    logic        out_free;

    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_item_reg;
    out_item_t   out_item_next;

    logic [31:0] last_yaw_reg;
    logic [31:0] last_yaw_next;
    logic [31:0] cur_pitch_reg;
    logic [31:0] cur_pitch_next;
    logic        mode_reg;
    logic        mode_next;
    logic [15:0] idle_cnt_reg;
    logic [15:0] idle_cnt_next;

    store_cmd_t  store_cmd;
    frame_dec_t  dec;

    // stage handshake
    assign out_free      = !out_valid_reg || out_chan.ready;
    assign s1_idle       = (s1_item_reg.operation == OP_IDLE);
    assign s1_adv        = s1_valid_reg && (!s1_idle || out_free);
    assign in_chan.ready = !s1_valid_reg || s1_adv;

    assign s1_valid_next = in_chan.valid ? 1'b1 : (s1_valid_reg && !s1_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_chan.ready ? s1_valid_next : s1_valid_reg;
        end
    end

    // entry register
    always_ff @(posedge clk)
    begin
        if (in_chan.valid && in_chan.ready)
        begin
            s1_item_reg <= in_chan.payload;
        end
    end

    // frame store
    assign store_cmd.wr   = s1_adv && !s1_idle;
    assign store_cmd.data = s1_item_reg.rx_byte;
    assign store_cmd.clr  = s1_adv && s1_idle;

    vfr_frame_store #(
        .FRAME_LEN (FRAME_LEN)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (store_cmd),
        .dec   (dec)
    );

    // idle event decode and state update
    always_comb
    begin
        idle_cnt_next  = idle_cnt_reg + 16'd1;
        last_yaw_next  = dec.ok ? dec.yaw : last_yaw_reg;
        cur_pitch_next = dec.ok ? dec.pitch : 32'd0;
        mode_next      = mode_reg;
        if (dec.ok && dec.mode_set)
        begin
            mode_next = 1'b1;
        end
        else if (dec.ok && dec.mode_clr)
        begin
            mode_next = 1'b0;
        end

        out_item_next.frame_ok        = dec.ok;
        out_item_next.yaw_bits        = last_yaw_next;
        out_item_next.pitch_bits      = cur_pitch_next;
        out_item_next.prev_pitch_bits = cur_pitch_reg;
        out_item_next.target_class    = dec.ok ? dec.cls : CLS_NONE;
        out_item_next.mode_windmill   = mode_next;
        if (!dec.ok)
        begin
            out_item_next.buzzer_cmd = BUZ_OFF;
        end
        else if (dec.cls != CLS_NONE)
        begin
            out_item_next.buzzer_cmd = BUZ_LOUD;
        end
        else
        begin
            out_item_next.buzzer_cmd = BUZ_SOFT;
        end
        out_item_next.frame_count = idle_cnt_next;
    end

    assign out_valid_next = store_cmd.clr ? 1'b1 : (out_valid_reg && !out_chan.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_yaw_reg  <= '0;
            cur_pitch_reg <= '0;
            mode_reg      <= 1'b0;
            idle_cnt_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (store_cmd.clr)
            begin
                last_yaw_reg  <= last_yaw_next;
                cur_pitch_reg <= cur_pitch_next;
                mode_reg      <= mode_next;
                idle_cnt_reg  <= idle_cnt_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (store_cmd.clr)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_chan.valid   = out_valid_reg;
    assign out_chan.payload = out_item_reg;

endmodule

/* sv/vfr_checker.sv */
// port-level checks of the frame receiver and their binding to the top level
`include "vision_frame_receiver_core_macros.svh"

module vfr_checker
    import vfr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    logic out_take;

    assign out_take = out_valid && out_ready;

    // a waiting result stays offered and unchanged
    `VFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `VFR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_item))

    // a bad frame reports no pitch, no class and a silent buzzer
    `VFR_ASSERT_IMPL(a_bad_frame, out_valid && !out_item.frame_ok, (out_item.pitch_bits == 32'd0) && (out_item.target_class == CLS_NONE) && (out_item.buzzer_cmd == BUZ_OFF))

    // results follow each other with a frame count one higher
    `VFR_ASSERT_NEXT(a_count_step, out_take, !out_valid || (out_item.frame_count == 16'($past(out_item.frame_count) + 16'd1)))

    // a bad frame leaves the mode where the previous result had it
    `VFR_ASSERT_NEXT(a_mode_keep, out_take, !out_valid || out_item.frame_ok || (out_item.mode_windmill == $past(out_item.mode_windmill)))

endmodule

bind vision_frame_receiver_core vfr_checker u_vfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_item  (out_chan.payload)
);

/* bench/vision_frame_receiver_core_tb.sv */
`timescale 1ns / 100ps
// testbench for the vision frame receiver: random and directed byte streams, checked per frame

module vision_frame_receiver_core_tb;
    import vfr_pkg::*;

    localparam int FRAME_LEN   = FRAME_LEN_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_HALF = 400;

    logic clk = 1'b0;
    logic rst_n;

    vfr_in_if  in_chan ();
    vfr_out_if out_chan ();

    vision_frame_receiver_core #(
        .FRAME_LEN (FRAME_LEN)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan.sink),
        .out_chan (out_chan.source)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // items waiting to be driven and frame results waiting to arrive
    in_item_t  pending_items[$];
    out_item_t expected_frames[$];

    // receiver state as the bench sees it
    logic [7:0]  rx_store [FRAME_LEN] = '{default: 8'h00};
    int unsigned fill_ptr       = 0;
    logic        store_full     = 1'b0;
    logic [31:0] good_yaw       = '0;
    logic [31:0] held_pitch     = '0;
    logic        windmill_latch = 1'b0;
    logic [15:0] idle_count     = '0;

    // run statistics
    int unsigned bytes_seen      = 0;
    int unsigned idles_seen      = 0;
    int unsigned good_frames     = 0;
    int unsigned counter_wraps   = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;

    int unsigned run_cycle    = 0;
    int unsigned quiet_cycles = 0;
    logic        gaps_on;

    out_item_t got_frame;
    out_item_t want_frame;

    // no idling on either side during one long stretch of the run
    assign gaps_on = !(run_cycle >= 300 && run_cycle < 900);

    task report_mismatch(input string field, input logic [31:0] got_v, input logic [31:0] want_v);
        $display("result %0d: %s got %0h expected %0h", results_checked, field, got_v, want_v);
        mismatches++;
    endtask

    // apply one accepted item to the receiver state, queue the frame result on idle
    task decode_rx_item(input in_item_t it);
        out_item_t res;
        res = '0;
        if (it.operation == OP_BYTE)
        begin
            bytes_seen++;
            if (!store_full && fill_ptr < FRAME_LEN)
            begin
                rx_store[fill_ptr] = it.rx_byte;
                fill_ptr++;
                if (fill_ptr >= FRAME_LEN)
                    store_full = 1'b1;
            end
        end
        else
        begin
            idles_seen++;
            idle_count = idle_count + 16'd1;
            if (idle_count == 16'd0)
                counter_wraps++;
            res.prev_pitch_bits = held_pitch;
            res.frame_ok = (rx_store[0] == HDR_BYTE) && (rx_store[FRAME_LEN-1] == TRL_BYTE);
            res.target_class = CLS_NONE;
            if (res.frame_ok)
            begin
                res.yaw_bits   = {rx_store[4], rx_store[3], rx_store[2], rx_store[1]};
                res.pitch_bits = {rx_store[8], rx_store[7], rx_store[6], rx_store[5]};
                if (rx_store[9] == CLASS_A_BYTE)
                    res.target_class = CLS_A;
                else if (rx_store[9] == CLASS_B_BYTE)
                    res.target_class = CLS_B;
                res.buzzer_cmd = (res.target_class != CLS_NONE) ? BUZ_LOUD : BUZ_SOFT;
                if (rx_store[10] == MODE_WM_BYTE)
                    windmill_latch = 1'b1;
                else if (rx_store[10] == MODE_ARM_BYTE)
                    windmill_latch = 1'b0;
                good_yaw = res.yaw_bits;
                good_frames++;
            end
            else
            begin
                res.yaw_bits   = good_yaw;
                res.pitch_bits = '0;
                res.buzzer_cmd = BUZ_OFF;
            end
            held_pitch = res.pitch_bits;
            store_full = 1'b0;
            fill_ptr   = 0;
            res.mode_windmill = windmill_latch;
            res.frame_count   = idle_count;
            expected_frames.push_back(res);
        end
    endtask

    task push_item(input logic op, input logic [7:0] data);
        in_item_t it;
        it.operation = op;
        it.rx_byte   = data;
        pending_items.push_back(it);
    endtask

    // one full frame of bytes, no idle
    task push_frame(input logic [7:0] hdr, input logic [31:0] yaw, input logic [31:0] pitch,
                    input logic [7:0] cls, input logic [7:0] mode, input logic [7:0] trl);
        push_item(OP_BYTE, hdr);
        for (int i = 0; i < 4; i++)
            push_item(OP_BYTE, yaw[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            push_item(OP_BYTE, pitch[8*i +: 8]);
        push_item(OP_BYTE, cls);
        push_item(OP_BYTE, mode);
        push_item(OP_BYTE, trl);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_marker(input logic [7:0] good);
        return ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : good;
    endfunction

    // mostly well-formed frames, some noise and truncated frames
    task push_random_frames(input int unsigned count);
        int unsigned target;
        logic [7:0]  cls;
        logic [7:0]  mode;
        target = pending_items.size() + count;
        while (pending_items.size() < target)
        begin
            if ($urandom_range(99) < 70)
            begin
                case ($urandom_range(2))
                    0:       cls = CLASS_A_BYTE;
                    1:       cls = CLASS_B_BYTE;
                    default: cls = 8'($urandom_range(255));
                endcase
                case ($urandom_range(2))
                    0:       mode = MODE_WM_BYTE;
                    1:       mode = MODE_ARM_BYTE;
                    default: mode = 8'($urandom_range(255));
                endcase
                push_frame(pick_marker(HDR_BYTE), pick_word(), pick_word(), cls, mode,
                           pick_marker(TRL_BYTE));
                // trailing bytes past a full store
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(1, 4))
                        push_item(OP_BYTE, 8'($urandom_range(255)));
            end
            else
            begin
                repeat ($urandom_range(0, 14))
                    push_item(OP_BYTE, 8'($urandom_range(255)));
            end
            push_item(OP_IDLE, 8'($urandom_range(255)));
        end
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_chan.valid   <= 1'b0;
            in_chan.payload <= '0;
        end
        else
        begin
            if (in_chan.valid && in_chan.ready)
                decode_rx_item(in_chan.payload);
            if (!in_chan.valid || in_chan.ready)
            begin
                if (pending_items.size() != 0 && !(gaps_on && $urandom_range(99) < 24))
                begin
                    in_chan.valid   <= 1'b1;
                    in_chan.payload <= pending_items.pop_front();
                end
                else
                begin
                    in_chan.valid <= 1'b0;
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_chan.ready <= 1'b0;
        else
            out_chan.ready <= !(gaps_on && $urandom_range(99) < 24);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_chan.valid && out_chan.ready)
        begin
            got_frame = out_chan.payload;
            if (expected_frames.size() == 0)
            begin
                report_mismatch("unexpected result, frame_count", got_frame.frame_count, '0);
            end
            else
            begin
                want_frame = expected_frames.pop_front();
                if (got_frame.frame_ok !== want_frame.frame_ok)
                    report_mismatch("frame_ok", got_frame.frame_ok, want_frame.frame_ok);
                if (got_frame.yaw_bits !== want_frame.yaw_bits)
                    report_mismatch("yaw_bits", got_frame.yaw_bits, want_frame.yaw_bits);
                if (got_frame.pitch_bits !== want_frame.pitch_bits)
                    report_mismatch("pitch_bits", got_frame.pitch_bits, want_frame.pitch_bits);
                if (got_frame.prev_pitch_bits !== want_frame.prev_pitch_bits)
                    report_mismatch("prev_pitch_bits", got_frame.prev_pitch_bits,
                                    want_frame.prev_pitch_bits);
                if (got_frame.target_class !== want_frame.target_class)
                    report_mismatch("target_class", got_frame.target_class,
                                    want_frame.target_class);
                if (got_frame.mode_windmill !== want_frame.mode_windmill)
                    report_mismatch("mode_windmill", got_frame.mode_windmill,
                                    want_frame.mode_windmill);
                if (got_frame.buzzer_cmd !== want_frame.buzzer_cmd)
                    report_mismatch("buzzer_cmd", got_frame.buzzer_cmd, want_frame.buzzer_cmd);
                if (got_frame.frame_count !== want_frame.frame_count)
                    report_mismatch("frame_count", got_frame.frame_count, want_frame.frame_count);
            end
            results_checked++;
        end
    end

    // cycle and inactivity counters
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            run_cycle <= run_cycle + 1;
            if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog
    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        rst_n           = 1'b0;
        in_chan.valid   = 1'b0;
        in_chan.payload = '0;
        out_chan.ready  = 1'b0;

        // idle straight after reset decodes the zeroed store
        push_item(OP_IDLE, 8'hFF);
        // good frame with extreme words, class B, windmill, then bytes past a full store
        push_frame(HDR_BYTE, 32'hFFFF_FFFF, 32'h8000_0000, CLASS_B_BYTE, MODE_WM_BYTE, TRL_BYTE);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_IDLE, 8'h00);
        // short frame decoded over stale bytes
        push_item(OP_BYTE, HDR_BYTE);
        push_item(OP_BYTE, 8'h01);
        push_item(OP_IDLE, 8'h00);
        // broken header gives a bad frame
        push_item(OP_BYTE, 8'h00);
        push_item(OP_IDLE, 8'h00);

        push_random_frames(RANDOM_HALF);
        push_random_frames(RANDOM_HALF);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_chan.valid)
            @(posedge clk);
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d bytes and %0d idle events; %0d results compared", bytes_seen,
                 idles_seen, results_checked);
        $display("%0d good frames, frame counter wrapped %0d times, %0d mismatches",
                 good_frames, counter_wraps, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
